[src/snu_pkg.sv]
package snu_pkg;

    localparam int C_EXP_TABLE_BITS = 6;
    localparam int C_TIME_WIDTH     = 32;
    localparam int C_MAX_TABLE_BITS = 10;

    localparam int C_TIME_IN_W = 32;
    localparam int C_VAL_W     = 32;
    localparam int C_RATE_W    = 24;
    localparam int C_FRAC_W    = 16;
    localparam int C_N_W       = 5;
    // a gap this wide times a nonzero rate already puts the exponent at 32 or more
    localparam int C_DT_W      = C_FRAC_W + C_N_W;
    localparam int C_DT_MAX_W  = 40;
    localparam int C_MUL_W     = 32;
    localparam int C_CFG_IDX_W = 3;

    typedef enum logic [C_CFG_IDX_W-1:0] {
        CFG_MEM_RATE = 3'd0,
        CFG_THR_RATE = 3'd1,
        CFG_REFR_WGT = 3'd2,
        CFG_BASE_THR = 3'd3,
        CFG_REFR_TCK = 3'd4
    } t_cfg_idx;

    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = x_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (b > x) begin
                b = b >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (b != '0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // 2^(-f / 2^bits) in Q1.16, built from repeated square roots of one half
    function automatic logic [C_FRAC_W:0] exp2_entry(input int f, input int bits);
        logic [63:0]  roots [0:C_MAX_TABLE_BITS];
        logic [127:0] acc;
        for (int k = 0; k <= C_MAX_TABLE_BITS; k++) begin
            roots[k] = '0;
        end
        roots[1] = isqrt64(64'h8000_0000_0000_0000);
        for (int k = 2; k <= bits; k++) begin
            roots[k] = isqrt64(roots[k-1] << 32);
        end
        acc = 128'h1_0000_0000;
        for (int i = 0; i < bits; i++) begin
            if (f[i]) begin
                acc = (acc * 128'(roots[bits-i])) >> 32;
            end
        end
        return (C_FRAC_W + 1)'((acc[63:0] + 64'h8000) >> C_FRAC_W);
    endfunction

endpackage

[src/snu_evt_if.sv]
interface snu_evt_if;
    import snu_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [C_TIME_IN_W-1:0]    event_time;
    logic signed [C_VAL_W-1:0] weight_sum;

    modport source (output valid, event_time, weight_sum, input ready);
    modport sink (input valid, event_time, weight_sum, output ready);

endinterface

[src/snu_res_if.sv]
interface snu_res_if;
    import snu_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      accepted;
    logic                      fired;
    logic signed [C_VAL_W-1:0] potential;

    modport source (output valid, accepted, fired, potential, input ready);
    modport sink (input valid, accepted, fired, potential, output ready);

endinterface

[src/spike_response_neuron_update_unit.sv]
// channel   dir  handshake      payload
// i_evt     in   valid/ready    event_time, weight_sum
// o_res     out  valid/ready    accepted, fired, potential
// i_cfg_*   in   i_cfg_we only  i_cfg_idx, i_cfg_data
//
// before the first spike an item runs CHK, DP, DF, DS, ADD, CMP between accepts;
// after it DP, DF, DS rerun after ADD for the threshold exponential; drops end in CHK
// one 32x32 multiplier is shared: two passes per exponential (exponent, then scale)
// synchronous active-low reset clears state and config, no clearing pass
// the result register frees the input side; a held result stalls only the next finish
module spike_response_neuron_update_unit #(
    parameter int EXP_TABLE_BITS = snu_pkg::C_EXP_TABLE_BITS,
    parameter int TIME_WIDTH     = snu_pkg::C_TIME_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    snu_evt_if.sink                          i_evt,
    snu_res_if.source                        o_res,
    input  logic                             i_cfg_we,
    input  logic [snu_pkg::C_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [snu_pkg::C_VAL_W-1:0]     i_cfg_data
);
    import snu_pkg::*;

    localparam int C_TAB_DEPTH = 1 << EXP_TABLE_BITS;
    localparam int C_CMP_W     = (TIME_WIDTH > C_TIME_IN_W) ? TIME_WIDTH : C_TIME_IN_W;
    localparam int C_PROD_W    = 2 * C_MUL_W;
    localparam int C_SUM_W     = C_VAL_W + 2;
    localparam logic signed [C_SUM_W-1:0] C_SAT_HI = (C_SUM_W)'(64'sh7FFF_FFFF);
    localparam logic signed [C_SUM_W-1:0] C_SAT_LO = -(C_SUM_W)'(64'sh8000_0000);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_DP,
        S_DF,
        S_DS,
        S_ADD,
        S_CMP
    } t_state;

    t_state                    r_state;
    logic [C_RATE_W-1:0]       r_mdr;
    logic [C_RATE_W-1:0]       r_tdr;
    logic signed [C_VAL_W-1:0] r_rw;
    logic signed [C_VAL_W-1:0] r_bt;
    logic [C_TIME_IN_W-1:0]    r_rt;
    logic signed [C_VAL_W-1:0] r_pot;
    logic [TIME_WIDTH-1:0]     r_last_in;
    logic [TIME_WIDTH-1:0]     r_last_spk;
    logic                      r_spiked;
    logic [TIME_WIDTH-1:0]     r_now;
    logic signed [C_VAL_W-1:0] r_weight;
    logic [TIME_WIDTH-1:0]     r_dt;
    logic [TIME_WIDTH-1:0]     r_dt_t;
    logic                      r_which;
    logic [C_PROD_W-1:0]       r_prod;
    logic                      r_zero;
    logic [C_N_W-1:0]          r_n;
    logic signed [C_VAL_W:0]   r_dec;
    logic                      r_out_valid;
    logic                      r_out_acc;
    logic                      r_out_fired;
    logic signed [C_VAL_W-1:0] r_out_pot;

    logic [C_FRAC_W:0]         w_exp_tab [C_TAB_DEPTH];
    logic                      w_slot_free;
    logic                      w_out_load;
    logic [TIME_WIDTH-1:0]     w_elapsed;
    logic [C_CMP_W-1:0]        w_elapsed_ext;
    logic [C_CMP_W-1:0]        w_rt_ext;
    logic                      w_in_refr;
    logic [TIME_WIDTH-1:0]     w_since;
    logic signed [C_VAL_W-1:0] w_dv;
    logic [C_RATE_W-1:0]       w_rate;
    logic [C_VAL_W-1:0]        w_mag;
    logic [C_DT_W-1:0]         w_dt_lo;
    logic                      w_dt_big;
    logic                      w_dt_huge;
    logic [EXP_TABLE_BITS-1:0] w_idx;
    logic [C_MUL_W-1:0]        w_mul_a;
    logic [C_MUL_W-1:0]        w_mul_b;
    logic [C_PROD_W-1:0]       w_prod;
    logic [C_VAL_W-1:0]        w_shr;
    logic [C_VAL_W-1:0]        w_mag_dec;
    logic signed [C_VAL_W:0]   w_dec;
    logic signed [C_SUM_W-1:0] w_sum;
    logic signed [C_SUM_W-1:0] w_thr;
    logic                      w_fire;

    for (genvar g = 0; g < C_TAB_DEPTH; g++) begin : g_tab
        assign w_exp_tab[g] = exp2_entry(g, EXP_TABLE_BITS);
    end

    assign i_evt.ready    = (r_state == S_IDLE);
    assign o_res.valid    = r_out_valid;
    assign o_res.accepted = r_out_acc;
    assign o_res.fired    = r_out_fired;
    assign o_res.potential = r_out_pot;

    assign w_slot_free   = !r_out_valid || o_res.ready;
    assign w_elapsed     = r_now - r_last_spk;
    assign w_elapsed_ext = C_CMP_W'(w_elapsed);
    assign w_rt_ext      = C_CMP_W'(r_rt);
    assign w_in_refr     = r_spiked && (w_elapsed_ext < w_rt_ext);
    assign w_since       = TIME_WIDTH'(w_elapsed_ext - w_rt_ext);

    // a result item is loaded on a drop or at the end of an accepted item
    assign w_out_load = w_slot_free &&
                        (((r_state == S_CHK) && w_in_refr) || (r_state == S_CMP));

    // shared exponential: membrane potential first, then refractory threshold
    assign w_dv      = r_which ? r_rw : r_pot;
    assign w_rate    = r_which ? r_tdr : r_mdr;
    assign w_mag     = w_dv[C_VAL_W-1] ? (~w_dv + 1'b1) : w_dv;
    assign w_dt_lo   = C_DT_W'(r_dt);
    assign w_dt_big  = (r_dt >> C_DT_W) != '0;
    assign w_dt_huge = (r_dt >> C_DT_MAX_W) != '0;
    assign w_idx     = r_prod[C_FRAC_W-1 -: EXP_TABLE_BITS];

    always_comb begin
        case (r_state)
            S_DP: begin
                w_mul_a = C_MUL_W'(w_dt_lo);
                w_mul_b = C_MUL_W'(w_rate);
            end
            default: begin
                w_mul_a = w_mag;
                w_mul_b = C_MUL_W'(w_exp_tab[w_idx]);
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    assign w_shr     = r_prod[C_FRAC_W+C_VAL_W-1:C_FRAC_W] >> r_n;
    assign w_mag_dec = r_zero ? '0 : w_shr;
    assign w_dec     = w_dv[C_VAL_W-1] ? -$signed({1'b0, w_mag_dec})
                                       : $signed({1'b0, w_mag_dec});

    assign w_sum  = C_SUM_W'(r_weight) + C_SUM_W'(r_dec);
    assign w_thr  = C_SUM_W'(r_bt) + C_SUM_W'(r_dec);
    assign w_fire = C_SUM_W'(r_pot) >= w_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mdr       <= '0;
            r_tdr       <= '0;
            r_rw        <= '0;
            r_bt        <= '0;
            r_rt        <= '0;
            r_pot       <= '0;
            r_last_in   <= '0;
            r_last_spk  <= '0;
            r_spiked    <= 1'b0;
            r_which     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MEM_RATE: r_mdr <= i_cfg_data[C_RATE_W-1:0];
                    CFG_THR_RATE: r_tdr <= i_cfg_data[C_RATE_W-1:0];
                    CFG_REFR_WGT: r_rw  <= i_cfg_data;
                    CFG_BASE_THR: r_bt  <= i_cfg_data;
                    CFG_REFR_TCK: r_rt  <= i_cfg_data;
                    default: ;
                endcase
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_evt.valid) begin
                        r_now    <= TIME_WIDTH'(i_evt.event_time);
                        r_weight <= i_evt.weight_sum;
                        r_state  <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (w_in_refr) begin
                        if (w_slot_free) begin
                            r_out_acc   <= 1'b0;
                            r_out_fired <= 1'b0;
                            r_out_pot   <= r_pot;
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_dt    <= r_now - r_last_in;
                        r_dt_t  <= w_since;
                        r_which <= 1'b0;
                        r_state <= S_DP;
                    end
                end
                S_DP: begin
                    r_prod  <= w_prod;
                    r_zero  <= w_dt_huge || ((w_rate != '0) && w_dt_big);
                    r_state <= S_DF;
                end
                S_DF: begin
                    // integer part of the exponent becomes the final right shift
                    r_n     <= r_prod[C_FRAC_W+C_N_W-1:C_FRAC_W];
                    r_zero  <= r_zero || (r_prod[C_PROD_W-1:C_DT_W] != '0);
                    r_prod  <= w_prod;
                    r_state <= S_DS;
                end
                S_DS: begin
                    r_dec   <= w_dec;
                    r_state <= r_which ? S_CMP : S_ADD;
                end
                S_ADD: begin
                    if (w_sum > C_SAT_HI) begin
                        r_pot <= C_VAL_W'(C_SAT_HI);
                    end else if (w_sum < C_SAT_LO) begin
                        r_pot <= C_VAL_W'(C_SAT_LO);
                    end else begin
                        r_pot <= C_VAL_W'(w_sum);
                    end
                    r_last_in <= r_now;
                    if (r_spiked) begin
                        r_which <= 1'b1;
                        r_dt    <= r_dt_t;
                        r_state <= S_DP;
                    end else begin
                        r_dec   <= '0;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (w_slot_free) begin
                        r_out_acc   <= 1'b1;
                        r_out_fired <= w_fire;
                        if (w_fire) begin
                            r_pot      <= '0;
                            r_out_pot  <= '0;
                            r_last_spk <= r_now;
                            r_spiked   <= 1'b1;
                        end else begin
                            r_out_pot <= r_pot;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
    import snu_pkg::*;

    typedef struct packed {
        logic                      accepted;
        logic                      fired;
        logic signed [C_VAL_W-1:0] potential;
    } res_t;

    typedef struct {
        bit          is_cfg;
        t_cfg_idx    idx;
        logic [31:0] a;
        logic [31:0] b;
        bit          chk;
        res_t        want;
    } stim_row_t;

    localparam int    TABLE_LEN = 1 << C_EXP_TABLE_BITS;
    localparam longint VAL_MAX  = 64'sd2147483647;
    localparam longint VAL_MIN  = -64'sd2147483648;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [C_CFG_IDX_W-1:0] i_cfg_idx;
    logic [C_VAL_W-1:0]     i_cfg_data;

    snu_evt_if evt_if ();
    snu_res_if res_if ();

    spike_response_neuron_update_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_evt      (evt_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // neuron mirror: config and state
    logic [C_RATE_W-1:0]       cfg_mem_rate;
    logic [C_RATE_W-1:0]       cfg_thr_rate;
    logic signed [C_VAL_W-1:0] cfg_refr_wgt;
    logic signed [C_VAL_W-1:0] cfg_base_thr;
    logic [31:0]               cfg_refr_ticks;
    logic signed [C_VAL_W-1:0] mem_pot;
    logic [31:0]               last_in_t;
    logic [31:0]               last_spike_t;
    logic                      spiked;
    logic [C_FRAC_W:0]         exp_frac [TABLE_LEN];

    res_t      pending_results[$];
    stim_row_t dir_rows[$];
    int        err_count = 0;
    int        burst_left = 0;
    bit        item_chk;
    res_t      item_want;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic longint unsigned root_u64(longint unsigned x);
        longint unsigned rem;
        longint unsigned res;
        longint unsigned one;
        rem = x;
        res = 0;
        one = 64'h4000_0000_0000_0000;
        while (one > rem) one = one >> 2;
        while (one != 0) begin
            if (rem >= res + one) begin
                rem = rem - (res + one);
                res = (res >> 1) + one;
            end else begin
                res = res >> 1;
            end
            one = one >> 2;
        end
        return res;
    endfunction

    // 2^(-f/64) in Q1.16 from chained square roots of one half in Q0.32
    function automatic void build_exp_table();
        longint unsigned roots [C_EXP_TABLE_BITS+1];
        longint unsigned acc;
        roots[0] = 0;
        roots[1] = root_u64(64'h8000_0000_0000_0000);
        for (int k = 2; k <= C_EXP_TABLE_BITS; k++) begin
            roots[k] = root_u64(roots[k-1] << 32);
        end
        for (int f = 0; f < TABLE_LEN; f++) begin
            acc = 64'h1_0000_0000;
            for (int i = 0; i < C_EXP_TABLE_BITS; i++) begin
                if (((f >> i) & 1) != 0) begin
                    acc = (acc * roots[C_EXP_TABLE_BITS-i]) >> 32;
                end
            end
            exp_frac[f] = (C_FRAC_W + 1)'((acc + 64'h8000) >> 16);
        end
    endfunction

    // v * 2^-(dt*rate/2^16), magnitude truncated
    function automatic longint decayed(logic signed [C_VAL_W-1:0] v, logic [31:0] dt,
                                       logic [C_RATE_W-1:0] rate);
        logic [63:0]                 prod;
        logic [63:0]                 whole;
        logic [C_EXP_TABLE_BITS-1:0] idx;
        longint unsigned             mag;
        longint unsigned             scaled;
        prod  = 64'(dt) * 64'(rate);
        whole = prod >> C_FRAC_W;
        if (whole >= 32) return 0;
        idx    = prod[C_FRAC_W-1 -: C_EXP_TABLE_BITS];
        mag    = (v < 0) ? -longint'(v) : longint'(v);
        scaled = ((mag * exp_frac[idx]) >> C_FRAC_W) >> whole;
        return (v < 0) ? -longint'(scaled) : longint'(scaled);
    endfunction

    function automatic res_t neuron_step(logic [31:0] now, logic signed [C_VAL_W-1:0] w);
        res_t        r;
        logic [31:0] elapsed;
        logic [31:0] since;
        longint      total;
        longint      dyn;
        since      = 0;
        dyn        = 0;
        r.accepted = 1'b1;
        r.fired    = 1'b0;
        if (spiked) begin
            elapsed = now - last_spike_t;
            if (elapsed < cfg_refr_ticks) begin
                r.accepted  = 1'b0;
                r.potential = mem_pot;
                return r;
            end
            since = elapsed - cfg_refr_ticks;
        end
        total = longint'(w) + decayed(mem_pot, now - last_in_t, cfg_mem_rate);
        if (total > VAL_MAX) total = VAL_MAX;
        if (total < VAL_MIN) total = VAL_MIN;
        mem_pot   = C_VAL_W'(total);
        last_in_t = now;
        if (spiked) dyn = decayed(cfg_refr_wgt, since, cfg_thr_rate);
        // compare in 64 bits so threshold plus dynamic part cannot wrap
        if (longint'(mem_pot) >= longint'(cfg_base_thr) + dyn) begin
            r.fired      = 1'b1;
            mem_pot      = '0;
            last_spike_t = now;
            spiked       = 1'b1;
        end
        r.potential = mem_pot;
        return r;
    endfunction

    always @(posedge i_clk) begin
        res_t got;
        res_t want;
        if (!i_rst_n) begin
            cfg_mem_rate   = '0;
            cfg_thr_rate   = '0;
            cfg_refr_wgt   = '0;
            cfg_base_thr   = '0;
            cfg_refr_ticks = '0;
            mem_pot        = '0;
            last_in_t      = '0;
            last_spike_t   = '0;
            spiked         = 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got.accepted  = res_if.accepted;
                got.fired     = res_if.fired;
                got.potential = res_if.potential;
                if (pending_results.size() == 0) begin
                    $error("result item with nothing expected");
                    err_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.accepted !== want.accepted) begin
                        $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
                        err_count++;
                    end
                    if (got.fired !== want.fired) begin
                        $error("fired: expected %0d, got %0d", want.fired, got.fired);
                        err_count++;
                    end
                    if (got.potential !== want.potential) begin
                        $error("potential: expected %0d, got %0d", want.potential,
                               got.potential);
                        err_count++;
                    end
                end
            end
            if (evt_if.valid && evt_if.ready) begin
                want = neuron_step(evt_if.event_time, evt_if.weight_sum);
                pending_results.push_back(item_chk ? item_want : want);
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_MEM_RATE: cfg_mem_rate   = i_cfg_data[C_RATE_W-1:0];
                    CFG_THR_RATE: cfg_thr_rate   = i_cfg_data[C_RATE_W-1:0];
                    CFG_REFR_WGT: cfg_refr_wgt   = i_cfg_data;
                    CFG_BASE_THR: cfg_base_thr   = i_cfg_data;
                    CFG_REFR_TCK: cfg_refr_ticks = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // result side back-pressure
    initial begin
        int hold;
        int pick;
        res_if.ready = 1'b0;
        forever begin
            pick = $urandom_range(0, 99);
            @(negedge i_clk);
            if (pick < 60) begin
                res_if.ready <= 1'b1;
                hold = $urandom_range(1, 20);
            end else if (pick < 90) begin
                res_if.ready <= 1'b0;
                hold = $urandom_range(1, 3);
            end else if (pick < 97) begin
                res_if.ready <= 1'b0;
                hold = $urandom_range(10, 60);
            end else begin
                res_if.ready <= 1'b1;
                hold = $urandom_range(100, 300);
            end
            repeat (hold - 1) @(negedge i_clk);
        end
    end

    task automatic send_item(logic [31:0] t, logic [31:0] w, bit chk, res_t want);
        int gap;
        int pick;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                burst_left = $urandom_range(20, 60);
                gap = 0;
            end else if (pick < 80) begin
                gap = $urandom_range(0, 3);
            end else if (pick < 95) begin
                gap = $urandom_range(4, 15);
            end else begin
                gap = $urandom_range(30, 80);
            end
        end
        @(negedge i_clk);
        if (gap > 0) begin
            evt_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        evt_if.valid      <= 1'b1;
        evt_if.event_time <= t;
        evt_if.weight_sum <= w;
        item_chk          <= chk;
        item_want         <= want;
        do @(posedge i_clk); while (!evt_if.ready);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        evt_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic void add_cfg(t_cfg_idx idx, logic [31:0] val);
        stim_row_t row;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.a      = val;
        row.b      = '0;
        row.chk    = 1'b0;
        row.want   = '0;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_evt(logic [31:0] t, logic [31:0] w);
        stim_row_t row;
        row.is_cfg = 1'b0;
        row.idx    = CFG_MEM_RATE;
        row.a      = t;
        row.b      = w;
        row.chk    = 1'b0;
        row.want   = '0;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_typed(logic [31:0] t, logic [31:0] w, logic acc, logic fir,
                                      logic [31:0] pot);
        stim_row_t row;
        row.is_cfg = 1'b0;
        row.idx    = CFG_MEM_RATE;
        row.a      = t;
        row.b      = w;
        row.chk    = 1'b1;
        row.want   = '{accepted: acc, fired: fir, potential: pot};
        dir_rows.push_back(row);
    endfunction

    function automatic logic [31:0] pick_rate();
        case ($urandom_range(0, 4))
            0: return 32'h0;
            1: return 32'h00FF_FFFF;
            2: return $urandom_range(1, 255);
            3: return $urandom_range(256, 32'h3_0000);
            default: return $urandom & 32'h00FF_FFFF;
        endcase
    endfunction

    function automatic logic [31:0] pick_level();
        case ($urandom_range(0, 6))
            0: return 32'h0;
            1: return $urandom_range(32'h8000, 32'h8_0000);
            2: return 32'h0 - $urandom_range(32'h8000, 32'h8_0000);
            3: return $urandom;
            4: return 32'h7FFF_FFFF;
            5: return 32'h8000_0000;
            default: return $urandom_range(32'h1000, 32'h4_0000);
        endcase
    endfunction

    initial begin
        logic [31:0] t_now;
        logic [31:0] w;
        logic [31:0] ticks;
        int          pick;
        build_exp_table();
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        evt_if.valid      = 1'b0;
        evt_if.event_time = '0;
        evt_if.weight_sum = '0;
        item_chk          = 1'b0;
        item_want         = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // all registers zero: nothing decays, threshold zero
        add_typed(32'd0, 32'h0, 1'b1, 1'b1, 32'h0);
        add_cfg(CFG_BASE_THR, 32'h7FFF_FFFF);
        add_cfg(CFG_REFR_TCK, 32'd10);
        add_typed(32'd3, 32'h5, 1'b0, 1'b0, 32'h0);               // inside refractory
        add_typed(32'd10, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h0);      // refractory just over
        add_typed(32'd12, 32'h1, 1'b0, 1'b0, 32'h0);
        add_typed(32'd20, 32'h8000_0000, 1'b1, 1'b0, 32'h8000_0000);
        add_typed(32'd21, 32'h8000_0000, 1'b1, 1'b0, 32'h8000_0000); // negative saturation
        add_cfg(CFG_MEM_RATE, 32'h00FF_FFFF);
        add_typed(32'd22, 32'h0, 1'b1, 1'b0, 32'h0);              // exponent past 31
        add_typed(32'd23, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h0);
        add_cfg(CFG_REFR_WGT, 32'h7FFF_FFFF);
        add_cfg(CFG_THR_RATE, 32'h0);
        add_cfg(CFG_REFR_TCK, 32'd0);
        add_typed(32'd23, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'h7FFF_FFFF); // threshold sum no wrap
        add_cfg(CFG_BASE_THR, 32'h8000_0000);
        add_cfg(CFG_REFR_WGT, 32'h8000_0000);
        add_typed(32'd30, 32'h8000_0000, 1'b1, 1'b1, 32'h0);
        add_cfg(CFG_REFR_TCK, 32'hFFFF_FFFF);
        add_typed(32'd31, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0);
        add_typed(32'd29, 32'h5, 1'b1, 1'b1, 32'h0);              // time going backwards
        add_cfg(CFG_MEM_RATE, 32'h0000_B8AA);
        add_cfg(CFG_THR_RATE, 32'h0000_2E2A);
        add_cfg(CFG_REFR_WGT, 32'h0008_0000);
        add_cfg(CFG_BASE_THR, 32'h0004_0000);
        add_cfg(CFG_REFR_TCK, 32'd3);
        add_evt(32'd100, 32'h0003_0000);
        add_evt(32'd101, 32'h0001_8000);
        add_evt(32'd101, 32'h0001_0000);
        add_evt(32'd103, 32'h0005_0000);
        add_evt(32'd104, 32'h0005_0000);
        add_evt(32'd110, 32'hFFFF_0000);
        add_evt(32'd111, 32'hFFF8_0000);
        add_evt(32'd113, 32'h0010_0000);
        add_evt(32'hFFFF_FFF0, 32'h000A_0000);
        add_evt(32'h0000_0005, 32'h000A_0000);
        add_evt(32'h8000_0000, 32'h7FFF_FFFF);
        add_evt(32'h8000_0001, 32'h7FFF_FFFF);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                wait_idle();
                cfg_write(dir_rows[i].idx, dir_rows[i].a);
            end else begin
                send_item(dir_rows[i].a, dir_rows[i].b, dir_rows[i].chk, dir_rows[i].want);
            end
        end

        t_now = 32'h8000_0001;
        for (int phase = 0; phase < 6; phase++) begin
            wait_idle();
            case ($urandom_range(0, 4))
                0: ticks = 32'h0;
                1: ticks = $urandom_range(1, 20);
                2: ticks = $urandom_range(21, 400);
                3: ticks = $urandom;
                default: ticks = 32'hFFFF_FFFF;
            endcase
            cfg_write(CFG_MEM_RATE, pick_rate());
            cfg_write(CFG_THR_RATE, pick_rate());
            cfg_write(CFG_REFR_WGT, pick_level());
            cfg_write(CFG_BASE_THR, pick_level());
            cfg_write(CFG_REFR_TCK, ticks);
            for (int n = 0; n < 190; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    t_now = t_now;
                end else if (pick < 85) begin
                    t_now = t_now + $urandom_range(1, 6);
                end else if (pick < 95) begin
                    t_now = t_now + $urandom_range(7, 200);
                end else if (pick < 98) begin
                    t_now = t_now + $urandom_range(1, 32'h100_0000);
                end else begin
                    // arbitrary time, often backwards
                    t_now = $urandom;
                end
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    w = $urandom_range(0, 32'h6_0000) - 32'h2_0000;
                end else if (pick < 90) begin
                    w = $urandom;
                end else if (pick < 95) begin
                    w = 32'h7FFF_FFFF;
                end else begin
                    w = 32'h8000_0000;
                end
                send_item(t_now, w, 1'b0, '0);
                if ($urandom_range(0, 99) == 0) wait_idle();
            end
        end

        wait_idle();
        repeat (30) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
